>>> hdl/eme_pkg.sv
`default_nettype none
package eme_pkg;

  localparam int DEF_FRAC_BITS = 16;

  localparam int COUNT_W  = 32;
  localparam int TIME_W   = 64;
  localparam int CPR_W    = 16;
  localparam int LEAD_W   = 8;
  localparam int VAL_W    = 32;
  localparam int QUOT_W   = 33;
  localparam int MUL_B_W  = 33;
  localparam int LEAD_US_W = 28;
  localparam int RPM_SC_W  = 26;

  // default datapath width at the default fraction bits
  localparam int DEF_DATA_W = 80;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_COUNTS_PER_REV = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LEAD_MM        = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HOME_POSITION  = 2'd2;

  localparam logic [CPR_W-1:0]  CPR_RESET  = 16'd8192;
  localparam logic [LEAD_W-1:0] LEAD_RESET = 8'd16;
  localparam logic [VAL_W-1:0]  HOME_RESET = 32'd4250010;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_HOME   = 1'b1;

  localparam logic [19:0]         US_PER_S   = 20'd1000000;
  localparam logic [RPM_SC_W-1:0] RPM_SCALE  = 26'd60000000;

  typedef struct packed {
    logic              func;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  time_us;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] speed_rpm;
    logic signed [VAL_W-1:0] position_mm;
    logic signed [VAL_W-1:0] velocity_mm_s;
    logic signed [VAL_W-1:0] accel_mm_s2;
    logic                    zero_interval;
  } out_item_t;

  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [QUOT_W-1:0] quot;
  } div_res_t;

  // signed quotient clamped to 32 bits
  function automatic logic signed [VAL_W-1:0] sat_quot(input logic neg,
                                                        input logic [QUOT_W-1:0] q,
                                                        input logic ovf);
    logic signed [VAL_W-1:0] r;
    if (!neg) begin
      if (ovf || (q > 33'h07FFFFFFF)) begin
        r = 32'sh7FFFFFFF;
      end else begin
        r = $signed(q[VAL_W-1:0]);
      end
    end else begin
      if (ovf || (q > 33'h080000000)) begin
        r = 32'sh80000000;
      end else begin
        r = $signed(32'd0 - q[VAL_W-1:0]);
      end
    end
    return r;
  endfunction

  // position plus signed increment, clamped to 32 bits
  function automatic logic signed [VAL_W-1:0] sat_pos(input logic signed [VAL_W-1:0] pos,
                                                       input logic neg,
                                                       input logic [QUOT_W-1:0] q,
                                                       input logic ovf);
    logic [QUOT_W:0]          m;
    logic signed [QUOT_W+1:0] inc;
    logic signed [QUOT_W+1:0] sum;
    logic signed [VAL_W-1:0]  r;
    m = ovf ? {1'b1, {QUOT_W{1'b0}}} : {1'b0, q};
    inc = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    sum = $signed({{(QUOT_W+2-VAL_W){pos[VAL_W-1]}}, pos}) + inc;
    if (sum > 35'sh007FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (sum < -35'sh0080000000) begin
      r = 32'sh80000000;
    end else begin
      r = sum[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/encoder_motion_estimator.sv
`default_nettype none
// Encoder motion estimator. Each sample item (func 0) carries an encoder count and a
// microsecond timestamp; the block returns one result item with speed in RPM, linear
// position, linear velocity and acceleration, all signed fixed point with FRAC_BITS
// fraction bits and saturated to 32 bits, plus a flag that is set when the time
// difference was zero (rates then repeat their last values). A home item (func 1) loads
// the position from the home_position register. One item is worked on at a time. A
// sample is computed by one shared shift-and-add multiplier and one restoring divider,
// each producing one bit per cycle, run five and four times in turn (only once each
// when the time difference is zero; an overflowing quotient ends a divider pass early).
// A home item goes from the idle state straight to the done state and the output register.
// The result waits in an output register, and the next item may be taken meanwhile; a
// finished item waits until that register is free.
// Registers are to be written through the cfg port only while the block is idle;
// the block itself does not enforce this.
module encoder_motion_estimator #(
  parameter int FRAC_BITS = eme_pkg::DEF_FRAC_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire eme_pkg::in_item_t                   in_item,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output eme_pkg::out_item_t                       out_item,
  input  wire logic                                cfg_we,
  input  wire logic [eme_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire logic [eme_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int NUM_W  = eme_pkg::COUNT_W + eme_pkg::LEAD_US_W + FRAC_BITS;
  localparam int DEN_W  = eme_pkg::TIME_W + eme_pkg::CPR_W;
  localparam int DATA_W = (NUM_W > DEN_W) ? NUM_W : DEN_W;
  localparam int VW     = eme_pkg::VAL_W;
  localparam int QW     = eme_pkg::QUOT_W;
  localparam int BW     = eme_pkg::MUL_B_W;

  localparam logic [DATA_W-1:0] RPM_SC =
    {{(DATA_W-eme_pkg::RPM_SC_W){1'b0}}, eme_pkg::RPM_SCALE} << FRAC_BITS;
  localparam logic [DATA_W-1:0] US_A =
    {{(DATA_W-20){1'b0}}, eme_pkg::US_PER_S};

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_INC_MUL = 11'b000_0000_0010,
    S_INC_DIV = 11'b000_0000_0100,
    S_DEN_MUL = 11'b000_0000_1000,
    S_SPD_MUL = 11'b000_0001_0000,
    S_SPD_DIV = 11'b000_0010_0000,
    S_VEL_MUL = 11'b000_0100_0000,
    S_VEL_DIV = 11'b000_1000_0000,
    S_ACC_MUL = 11'b001_0000_0000,
    S_ACC_DIV = 11'b010_0000_0000,
    S_DONE    = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [eme_pkg::CPR_W-1:0]     cpr_r;
  logic [eme_pkg::LEAD_W-1:0]    lead_r;
  logic signed [VW-1:0]          home_r;

  logic [eme_pkg::COUNT_W-1:0]   last_count_r;
  logic [eme_pkg::TIME_W-1:0]    last_time_r;
  logic signed [VW-1:0]          last_vel_r;
  logic signed [VW-1:0]          position_r;
  logic signed [VW-1:0]          last_speed_r;
  logic signed [VW-1:0]          last_accel_r;
  logic                          flag_r;

  logic [eme_pkg::COUNT_W-1:0]   mag_r;
  logic                          neg_r;
  logic [eme_pkg::TIME_W-1:0]    dt_r;
  logic [eme_pkg::LEAD_US_W-1:0] lead_us_r;
  logic [DATA_W-1:0]             den_r;
  logic signed [VW-1:0]          spd_new_r;
  logic signed [VW-1:0]          vel_new_r;

  logic                          out_valid_r;
  eme_pkg::out_item_t            out_item_r;

  logic                          mul_start_r, mul_start_nxt;
  logic                          div_start_r, div_start_nxt;
  logic [DATA_W-1:0]             mul_a;
  logic [BW-1:0]                 mul_b;
  logic [DATA_W-1:0]             mul_prod;
  logic                          mul_done;
  logic [DATA_W-1:0]             div_den;
  eme_pkg::div_res_t             div_res;

  logic                          accept;
  logic                          out_free;
  logic [eme_pkg::COUNT_W-1:0]   raw_diff;
  logic [eme_pkg::CPR_W-1:0]     cpr_eff;
  logic signed [VW:0]            dv;
  logic                          dneg;
  logic [BW-1:0]                 dv_mag;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign raw_diff = in_item.count - last_count_r;
  assign cpr_eff  = (cpr_r == '0) ? eme_pkg::CPR_W'(1) : cpr_r;
  assign dv       = {vel_new_r[VW-1], vel_new_r} - {last_vel_r[VW-1], last_vel_r};
  assign dneg     = dv[VW];
  assign dv_mag   = dneg ? BW'(0) - BW'(dv) : BW'(dv);

  eme_mul #(.DATA_W(DATA_W), .B_W(BW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start_r),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  eme_div #(.DATA_W(DATA_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (mul_prod),
    .den   (div_den),
    .res   (div_res)
  );

  // operand selection
  always_comb begin
    mul_a   = US_A;
    mul_b   = {1'b0, mag_r};
    div_den = den_r;
    case (state_r)
      S_INC_MUL: begin
        mul_a = {{(DATA_W-eme_pkg::LEAD_W){1'b0}}, lead_r} << FRAC_BITS;
      end
      S_DEN_MUL: begin
        mul_a = {{(DATA_W-eme_pkg::TIME_W){1'b0}}, dt_r};
        mul_b = {{(BW-eme_pkg::CPR_W){1'b0}}, cpr_eff};
      end
      S_SPD_MUL: begin
        mul_a = RPM_SC;
      end
      S_VEL_MUL: begin
        mul_a = {{(DATA_W-eme_pkg::LEAD_US_W){1'b0}}, lead_us_r} << FRAC_BITS;
      end
      S_ACC_MUL: begin
        mul_b = dv_mag;
      end
      S_INC_DIV: begin
        div_den = {{(DATA_W-eme_pkg::CPR_W){1'b0}}, cpr_eff};
      end
      S_ACC_DIV: begin
        div_den = {{(DATA_W-eme_pkg::TIME_W){1'b0}}, dt_r};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_item.func == eme_pkg::FUNC_HOME) ? S_DONE : S_INC_MUL;
        end
      end
      S_INC_MUL: if (mul_done) state_nxt = S_INC_DIV;
      S_INC_DIV: begin
        if (div_res.done) begin
          state_nxt = (dt_r == '0) ? S_DONE : S_DEN_MUL;
        end
      end
      S_DEN_MUL: if (mul_done) state_nxt = S_SPD_MUL;
      S_SPD_MUL: if (mul_done) state_nxt = S_SPD_DIV;
      S_SPD_DIV: if (div_res.done) state_nxt = S_VEL_MUL;
      S_VEL_MUL: if (mul_done) state_nxt = S_VEL_DIV;
      S_VEL_DIV: if (div_res.done) state_nxt = S_ACC_MUL;
      S_ACC_MUL: if (mul_done) state_nxt = S_ACC_DIV;
      S_ACC_DIV: if (div_res.done) state_nxt = S_DONE;
      S_DONE:    if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
    mul_start_nxt = (state_nxt != state_r) &&
                    ((state_nxt == S_INC_MUL) || (state_nxt == S_DEN_MUL) ||
                     (state_nxt == S_SPD_MUL) || (state_nxt == S_VEL_MUL) ||
                     (state_nxt == S_ACC_MUL));
    div_start_nxt = (state_nxt != state_r) &&
                    ((state_nxt == S_INC_DIV) || (state_nxt == S_SPD_DIV) ||
                     (state_nxt == S_VEL_DIV) || (state_nxt == S_ACC_DIV));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mul_start_r  <= 1'b0;
      div_start_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      cpr_r        <= eme_pkg::CPR_RESET;
      lead_r       <= eme_pkg::LEAD_RESET;
      home_r       <= $signed(eme_pkg::HOME_RESET);
      last_count_r <= '0;
      last_time_r  <= '0;
      last_vel_r   <= '0;
      position_r   <= '0;
      last_speed_r <= '0;
      last_accel_r <= '0;
      flag_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mul_start_r <= mul_start_nxt;
      div_start_r <= div_start_nxt;

      if (cfg_we) begin
        case (cfg_addr)
          eme_pkg::REG_COUNTS_PER_REV: cpr_r  <= cfg_data[eme_pkg::CPR_W-1:0];
          eme_pkg::REG_LEAD_MM:        lead_r <= cfg_data[eme_pkg::LEAD_W-1:0];
          eme_pkg::REG_HOME_POSITION:  home_r <= $signed(cfg_data[VW-1:0]);
          default: begin
          end
        endcase
      end

      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            flag_r <= 1'b0;
            if (in_item.func == eme_pkg::FUNC_HOME) begin
              position_r <= home_r;
            end else begin
              last_count_r <= in_item.count;
              last_time_r  <= in_item.time_us;
            end
          end
        end
        S_INC_DIV: begin
          if (div_res.done) begin
            position_r <= eme_pkg::sat_pos(position_r, neg_r, div_res.quot, div_res.ovf);
            flag_r     <= (dt_r == '0);
          end
        end
        S_ACC_DIV: begin
          if (div_res.done) begin
            last_speed_r <= spd_new_r;
            last_vel_r   <= vel_new_r;
            last_accel_r <= eme_pkg::sat_quot(dneg, div_res.quot, div_res.ovf);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // item working values
  always_ff @(posedge clk) begin
    if (accept) begin
      neg_r     <= raw_diff[eme_pkg::COUNT_W-1];
      mag_r     <= raw_diff[eme_pkg::COUNT_W-1] ? (eme_pkg::COUNT_W'(0) - raw_diff) : raw_diff;
      dt_r      <= in_item.time_us - last_time_r;
      lead_us_r <= {{(eme_pkg::LEAD_US_W-eme_pkg::LEAD_W){1'b0}}, lead_r} *
                   {{(eme_pkg::LEAD_US_W-20){1'b0}}, eme_pkg::US_PER_S};
    end
    if ((state_r == S_DEN_MUL) && mul_done) begin
      den_r <= mul_prod;
    end
    if ((state_r == S_SPD_DIV) && div_res.done) begin
      spd_new_r <= eme_pkg::sat_quot(neg_r, div_res.quot, div_res.ovf);
    end
    if ((state_r == S_VEL_DIV) && div_res.done) begin
      vel_new_r <= eme_pkg::sat_quot(neg_r, div_res.quot, div_res.ovf);
    end
    if ((state_r == S_DONE) && out_free) begin
      out_item_r.speed_rpm     <= last_speed_r;
      out_item_r.position_mm   <= position_r;
      out_item_r.velocity_mm_s <= last_vel_r;
      out_item_r.accel_mm_s2   <= last_accel_r;
      out_item_r.zero_interval <= flag_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

>>> hdl/eme_mul.sv
`default_nettype none
module eme_mul #(
  parameter int DATA_W = eme_pkg::DEF_DATA_W,
  parameter int B_W    = eme_pkg::MUL_B_W
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] a,
  input  wire logic [B_W-1:0]    b,
  output logic [DATA_W-1:0]      prod,
  output logic                   done
);

  localparam int CNT_W = $clog2(B_W + 1);

  logic [DATA_W-1:0] a_r;
  logic [B_W-1:0]    b_r;
  logic [DATA_W-1:0] acc_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DATA_W-1:0] acc_nxt;

  // msb first shift and add, one multiplier bit per cycle
  assign acc_nxt = {acc_r[DATA_W-2:0], 1'b0} + (b_r[B_W-1] ? a_r : {DATA_W{1'b0}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(B_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[B_W-2:0], 1'b0};
    end
  end

  assign prod = acc_r;
  assign done = done_r;

endmodule
`default_nettype wire

>>> hdl/eme_div.sv
`default_nettype none
module eme_div #(
  parameter int DATA_W = eme_pkg::DEF_DATA_W
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] num,
  input  wire logic [DATA_W-1:0] den,
  output eme_pkg::div_res_t      res
);

  localparam int QW    = eme_pkg::QUOT_W;
  localparam int CNT_W = $clog2(QW + 1);

  logic [DATA_W-1:0] num_r;
  logic [DATA_W-1:0] den_r;
  logic [DATA_W-1:0] rem_r;
  logic [QW-1:0]     lo_r;
  logic [QW-1:0]     q_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              chk_r;
  logic              ovf_r;
  logic              done_r;

  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              ge;
  logic              too_big;

  // quotient would need more than QW bits
  assign too_big = {{QW{1'b0}}, num_r[DATA_W-1:QW]} >= den_r;

  assign trial = {rem_r, lo_r[QW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      chk_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        chk_r  <= 1'b1;
      end else if (busy_r && chk_r) begin
        chk_r <= 1'b0;
        cnt_r <= CNT_W'(QW);
        if (too_big) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      num_r <= num;
      den_r <= den;
      ovf_r <= 1'b0;
      q_r   <= '0;
    end else if (busy_r && chk_r) begin
      ovf_r <= too_big;
      rem_r <= {{QW{1'b0}}, num_r[DATA_W-1:QW]};
      lo_r  <= num_r[QW-1:0];
    end else if (busy_r) begin
      rem_r <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      lo_r  <= {lo_r[QW-2:0], 1'b0};
      q_r   <= {q_r[QW-2:0], ge};
    end
  end

  assign res.done = done_r;
  assign res.ovf  = ovf_r;
  assign res.quot = q_r;

endmodule
`default_nettype wire

>>> hdl/eme_checker.sv
`default_nettype none
module eme_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire eme_pkg::in_item_t  in_item,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire eme_pkg::out_item_t out_item
);

  // one item in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // home item passes through the done state into the output register when the output is free
  a_home_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_item.func == eme_pkg::FUNC_HOME) &&
    (!out_valid || out_ready) |=> ##1 out_valid)
    else $error("home item result missing");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("bad state after reset");

endmodule

bind encoder_motion_estimator eme_checker u_eme_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
`default_nettype wire
